// ===== sv/mpbp_pkg.sv =====
// Shared types, codes and the property type table for the properties parser.
package mpbp_pkg;

    localparam int unsigned MAX_PROPERTIES = 16;

    localparam int unsigned BL_W = 28;
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_LEN     = 4'd1;
    localparam logic [3:0] PH_ID      = 4'd2;
    localparam logic [3:0] PH_NUM     = 4'd3;
    localparam logic [3:0] PH_PVAR    = 4'd4;
    localparam logic [3:0] PH_SLEN_HI = 4'd5;
    localparam logic [3:0] PH_SLEN_LO = 4'd6;
    localparam logic [3:0] PH_SDATA   = 4'd7;
    localparam logic [3:0] PH_DONE    = 4'd8;

    localparam logic [2:0] T_BYTE    = 3'd0;
    localparam logic [2:0] T_TWO     = 3'd1;
    localparam logic [2:0] T_FOUR    = 3'd2;
    localparam logic [2:0] T_VAR     = 3'd3;
    localparam logic [2:0] T_BIN     = 3'd4;
    localparam logic [2:0] T_STR     = 3'd5;
    localparam logic [2:0] T_PAIR    = 3'd6;
    localparam logic [2:0] T_UNKNOWN = 3'd7;

    localparam logic [2:0] K_NUMERIC  = 3'd0;
    localparam logic [2:0] K_STR_HDR  = 3'd1;
    localparam logic [2:0] K_STR_BYTE = 3'd2;
    localparam logic [2:0] K_UNKNOWN  = 3'd3;
    localparam logic [2:0] K_BLK_OK   = 3'd4;
    localparam logic [2:0] K_BLK_ERR  = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  identifier;
        logic [31:0] value;
        logic [7:0]  payload_byte;
        logic        pair_part;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [3:0]      phase;
        logic [BL_W-1:0] bytes_left;
        logic [7:0]      prop_count;
        logic [7:0]      current_id;
        logic [2:0]      current_type;
        logic [31:0]     accumulator;
        logic [15:0]     field_bytes_left;
        logic [1:0]      varint_shift;
        logic            in_pair_value;
    } state_t;

    function automatic logic [2:0] classify(input logic [7:0] id);
        logic [2:0] t;
        unique case (id)
            8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: t = T_BYTE;
            8'h13, 8'h21, 8'h22, 8'h23:                             t = T_TWO;
            8'h02, 8'h11, 8'h18, 8'h27:                             t = T_FOUR;
            8'h0B:                                                  t = T_VAR;
            8'h09, 8'h16:                                           t = T_BIN;
            8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F:       t = T_STR;
            8'h26:                                                  t = T_PAIR;
            default:                                                t = T_UNKNOWN;
        endcase
        return t;
    endfunction

endpackage

// ===== sv/mpbp_parser.sv =====
// Parser state register and the per-byte step logic producing up to two results.
module mpbp_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           data_byte,
    input  logic                 start_block,
    output logic [1:0]           res_cnt,
    output mpbp_pkg::result_t    res0,
    output mpbp_pkg::result_t    res1
);

    mpbp_pkg::state_t st_reg;
    mpbp_pkg::state_t st_next;
    mpbp_pkg::result_t res [2];

    always_comb begin
        logic       done;
        logic       abort;
        logic [1:0] n;
        mpbp_pkg::state_t s;
        mpbp_pkg::result_t r;

        s     = st_reg;
        n     = 2'd0;
        done  = 1'b0;
        abort = 1'b0;
        r     = '0;
        res[0] = '0;
        res[1] = '0;

        if (start_block) begin
            s = '0;
            s.phase = mpbp_pkg::PH_LEN;
        end

        if (s.phase == mpbp_pkg::PH_LEN) begin
            s.bytes_left = s.bytes_left
                | (mpbp_pkg::BL_W'(data_byte[6:0]) << (5'(s.varint_shift) * 5'd7));
            if (data_byte[7]) begin
                if (s.varint_shift == 2'd3) begin
                    r = '0;
                    r.kind  = mpbp_pkg::K_BLK_ERR;
                    r.value = 32'(s.prop_count);
                    res[n[0]] = r;
                    n = n + 2'd1;
                    s.phase = mpbp_pkg::PH_DONE;
                end else begin
                    s.varint_shift = s.varint_shift + 2'd1;
                end
            end else begin
                s.varint_shift = 2'd0;
                if (s.bytes_left == '0) begin
                    r = '0;
                    r.kind = mpbp_pkg::K_BLK_OK;
                    res[n[0]] = r;
                    n = n + 2'd1;
                    s.phase = mpbp_pkg::PH_DONE;
                end else begin
                    s.phase = mpbp_pkg::PH_ID;
                end
            end
        end else if (s.phase >= mpbp_pkg::PH_ID && s.phase <= mpbp_pkg::PH_SDATA) begin
            if (s.bytes_left != '0) begin
                s.bytes_left = s.bytes_left - mpbp_pkg::BL_W'(1);
            end

            unique case (s.phase)
                mpbp_pkg::PH_ID: begin
                    s.current_id    = data_byte;
                    s.current_type  = mpbp_pkg::classify(data_byte);
                    s.in_pair_value = 1'b0;
                    s.accumulator   = '0;
                    s.varint_shift  = 2'd0;
                    unique case (s.current_type)
                        mpbp_pkg::T_UNKNOWN: begin
                            r = '0;
                            r.kind       = mpbp_pkg::K_UNKNOWN;
                            r.identifier = s.current_id;
                            res[n[0]] = r;
                            n = n + 2'd1;
                            done = 1'b1;
                        end
                        mpbp_pkg::T_BYTE: begin
                            s.field_bytes_left = 16'd1;
                            s.phase = mpbp_pkg::PH_NUM;
                        end
                        mpbp_pkg::T_TWO: begin
                            s.field_bytes_left = 16'd2;
                            s.phase = mpbp_pkg::PH_NUM;
                        end
                        mpbp_pkg::T_FOUR: begin
                            s.field_bytes_left = 16'd4;
                            s.phase = mpbp_pkg::PH_NUM;
                        end
                        mpbp_pkg::T_VAR: begin
                            s.phase = mpbp_pkg::PH_PVAR;
                        end
                        default: begin
                            s.phase = mpbp_pkg::PH_SLEN_HI;
                        end
                    endcase
                end
                mpbp_pkg::PH_NUM: begin
                    s.accumulator = {s.accumulator[23:0], data_byte};
                    if (s.field_bytes_left != 16'd0) begin
                        s.field_bytes_left = s.field_bytes_left - 16'd1;
                    end
                    if (s.field_bytes_left == 16'd0) begin
                        r = '0;
                        r.kind       = mpbp_pkg::K_NUMERIC;
                        r.identifier = s.current_id;
                        r.value      = s.accumulator;
                        res[n[0]] = r;
                        n = n + 2'd1;
                        done = 1'b1;
                    end
                end
                mpbp_pkg::PH_PVAR: begin
                    s.accumulator = s.accumulator
                        | (32'(data_byte[6:0]) << (5'(s.varint_shift) * 5'd7));
                    if (data_byte[7]) begin
                        if (s.varint_shift == 2'd3) begin
                            r = '0;
                            r.kind  = mpbp_pkg::K_BLK_ERR;
                            r.value = 32'(s.prop_count);
                            res[n[0]] = r;
                            n = n + 2'd1;
                            s.phase = mpbp_pkg::PH_DONE;
                            abort = 1'b1;
                        end else begin
                            s.varint_shift = s.varint_shift + 2'd1;
                        end
                    end else begin
                        r = '0;
                        r.kind       = mpbp_pkg::K_NUMERIC;
                        r.identifier = s.current_id;
                        r.value      = s.accumulator;
                        res[n[0]] = r;
                        n = n + 2'd1;
                        done = 1'b1;
                    end
                end
                mpbp_pkg::PH_SLEN_HI: begin
                    s.field_bytes_left = {data_byte, 8'd0};
                    s.phase = mpbp_pkg::PH_SLEN_LO;
                end
                mpbp_pkg::PH_SLEN_LO: begin
                    s.field_bytes_left = {s.field_bytes_left[15:8], data_byte};
                    r = '0;
                    r.kind       = mpbp_pkg::K_STR_HDR;
                    r.identifier = s.current_id;
                    r.value      = 32'(s.field_bytes_left);
                    r.pair_part  = s.in_pair_value;
                    res[n[0]] = r;
                    n = n + 2'd1;
                    s.phase = mpbp_pkg::PH_SDATA;
                end
                default: begin
                    r = '0;
                    r.kind         = mpbp_pkg::K_STR_BYTE;
                    r.identifier   = s.current_id;
                    r.payload_byte = data_byte;
                    r.pair_part    = s.in_pair_value;
                    res[n[0]] = r;
                    n = n + 2'd1;
                    if (s.field_bytes_left != 16'd0) begin
                        s.field_bytes_left = s.field_bytes_left - 16'd1;
                    end
                end
            endcase

            if (!abort) begin
                if (s.phase == mpbp_pkg::PH_SDATA && s.field_bytes_left == 16'd0) begin
                    if (s.current_type == mpbp_pkg::T_PAIR && !s.in_pair_value) begin
                        s.in_pair_value = 1'b1;
                        s.phase = mpbp_pkg::PH_SLEN_HI;
                    end else begin
                        done = 1'b1;
                    end
                end

                if (done) begin
                    s.prop_count = s.prop_count + 8'd1;
                    r = '0;
                    r.value = 32'(s.prop_count);
                    priority if (s.bytes_left == '0) begin
                        r.kind = mpbp_pkg::K_BLK_OK;
                        res[n[0]] = r;
                        n = n + 2'd1;
                        s.phase = mpbp_pkg::PH_DONE;
                    end else if (s.prop_count >= 8'(mpbp_pkg::MAX_PROPERTIES)) begin
                        r.kind = mpbp_pkg::K_BLK_ERR;
                        res[n[0]] = r;
                        n = n + 2'd1;
                        s.phase = mpbp_pkg::PH_DONE;
                    end else begin
                        s.phase = mpbp_pkg::PH_ID;
                    end
                end else if (s.bytes_left == '0) begin
                    r = '0;
                    r.kind  = mpbp_pkg::K_BLK_ERR;
                    r.value = 32'(s.prop_count);
                    res[n[0]] = r;
                    n = n + 2'd1;
                    s.phase = mpbp_pkg::PH_DONE;
                end
            end
        end

        if (n == 2'd1) begin
            res[0].last = 1'b1;
        end else if (n == 2'd2) begin
            res[1].last = 1'b1;
        end

        st_next = s;
        res_cnt = n;
    end

    assign res0 = res[0];
    assign res1 = res[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== sv/mpbp_res_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while pop is high.
module mpbp_res_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           push_cnt,
    input  mpbp_pkg::result_t    push0,
    input  mpbp_pkg::result_t    push1,
    input  logic                 pop,
    output logic                 head_valid,
    output mpbp_pkg::result_t    head,
    output logic                 room2
);

    mpbp_pkg::result_t              mem_reg [mpbp_pkg::RES_DEPTH];
    logic [mpbp_pkg::RES_PTR_W-1:0] wr_ptr_reg;
    logic [mpbp_pkg::RES_PTR_W-1:0] rd_ptr_reg;
    logic [mpbp_pkg::RES_PTR_W:0]   count_reg;
    logic [mpbp_pkg::RES_PTR_W:0]   count_next;
    logic                           do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign room2      = (count_reg <= (mpbp_pkg::RES_PTR_W + 1)'(mpbp_pkg::RES_DEPTH - 2));
    assign do_pop     = pop && head_valid;
    assign count_next = count_reg + (mpbp_pkg::RES_PTR_W + 1)'(push_cnt)
                        - (mpbp_pkg::RES_PTR_W + 1)'(do_pop);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_reg + mpbp_pkg::RES_PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + mpbp_pkg::RES_PTR_W'(push_cnt);
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + mpbp_pkg::RES_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/mqtt5_property_block_parser.sv =====
// Top level of the MQTT 5 properties-section byte parser.
// Usage:
//   Input channel (s_valid/s_ready): one byte of a properties section per
//   request; s_start_block marks the first byte of the length field and
//   abandons any section in progress.
//   Result channel (m_valid/m_ready): numeric records, string headers,
//   string bytes, unknown-id records and the final ok/error status with
//   the property count. m_last marks the final result caused by a byte.
// Path: an accepted byte is loaded into the input register; the step
//   result is then written from there into the result queue, and the
//   byte's first result is offered from the queue head.
// Throughput: one byte per cycle while the queue has room; each byte
//   yields zero, one or two results, and the one-result-per-cycle output
//   port sets the sustained rate when bytes yield two.
// Stall: while m_ready is low, results wait in a four-entry queue; the
//   step waits once fewer than two entries are free, and s_ready drops
//   when the input register is also held.
// Reset: synchronous active-low aresetn empties the queue and returns the
//   parser to idle; bytes without s_start_block are then ignored.
module mqtt5_property_block_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_identifier,
    output logic [31:0] m_value,
    output logic [7:0]  m_payload_byte,
    output logic        m_pair_part,
    output logic        m_last
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_start_reg;
    logic              step_en;
    logic              room2;
    logic [1:0]        res_cnt;
    logic [1:0]        push_cnt;
    mpbp_pkg::result_t res0;
    mpbp_pkg::result_t res1;
    mpbp_pkg::result_t head;

    assign step_en  = in_valid_reg && room2;
    assign s_ready  = !in_valid_reg || step_en;
    assign push_cnt = step_en ? res_cnt : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_start_block;
        end
    end

    mpbp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .data_byte   (in_byte_reg),
        .start_block (in_start_reg),
        .res_cnt     (res_cnt),
        .res0        (res0),
        .res1        (res1)
    );

    mpbp_res_fifo u_res_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (push_cnt),
        .push0      (res0),
        .push1      (res1),
        .pop        (m_ready),
        .head_valid (m_valid),
        .head       (head),
        .room2      (room2)
    );

    assign m_kind         = head.kind;
    assign m_identifier   = head.identifier;
    assign m_value        = head.value;
    assign m_payload_byte = head.payload_byte;
    assign m_pair_part    = head.pair_part;
    assign m_last         = head.last;

endmodule

// ===== verif/mqtt5_property_block_parser_tb.sv =====
// Self-checking testbench for the MQTT 5 properties-section byte parser.
module mqtt5_property_block_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1750;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_start_block;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_kind;
    logic [7:0]  m_identifier;
    logic [31:0] m_value;
    logic [7:0]  m_payload_byte;
    logic        m_pair_part;
    logic        m_last;

    mqtt5_property_block_parser DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_start_block (s_start_block),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_identifier  (m_identifier),
        .m_value       (m_value),
        .m_payload_byte(m_payload_byte),
        .m_pair_part   (m_pair_part),
        .m_last        (m_last)
    );

    logic [3:0]  ph;
    logic [31:0] blk_left;
    logic [7:0]  prop_cnt;
    logic [7:0]  cur_id;
    logic [2:0]  cur_type;
    logic [31:0] acc;
    logic [15:0] fld_left;
    logic [1:0]  vshift;
    logic        pair_val;

    mpbp_pkg::result_t expected_records[$];
    mpbp_pkg::result_t step_records[2];
    int                step_n;
    mpbp_pkg::result_t want;
    int      err_count = 0;
    int      bytes_sent = 0;
    bit      tx_gaps;
    bit      rx_stalls;
    logic [7:0] body[$];

    logic [7:0] known_ids[27] = '{
        8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A,
        8'h13, 8'h21, 8'h22, 8'h23, 8'h02, 8'h11, 8'h18, 8'h27,
        8'h0B, 8'h09, 8'h16, 8'h03, 8'h08, 8'h12, 8'h15, 8'h1A,
        8'h1C, 8'h1F, 8'h26
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [2:0] prop_type_of(input logic [7:0] id);
        unique case (id)
            8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A:
                return mpbp_pkg::T_BYTE;
            8'h13, 8'h21, 8'h22, 8'h23:                       return mpbp_pkg::T_TWO;
            8'h02, 8'h11, 8'h18, 8'h27:                       return mpbp_pkg::T_FOUR;
            8'h0B:                                            return mpbp_pkg::T_VAR;
            8'h09, 8'h16:                                     return mpbp_pkg::T_BIN;
            8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F: return mpbp_pkg::T_STR;
            8'h26:                                            return mpbp_pkg::T_PAIR;
            default:                                          return mpbp_pkg::T_UNKNOWN;
        endcase
    endfunction

    task automatic clear_parse_state();
        blk_left = '0;
        prop_cnt = '0;
        cur_id   = '0;
        cur_type = '0;
        acc      = '0;
        fld_left = '0;
        vshift   = '0;
        pair_val = 1'b0;
    endtask

    task automatic add_record(input logic [2:0] kind, input logic [7:0] id,
                              input logic [31:0] val, input logic [7:0] pb,
                              input logic pp);
        step_records[step_n] = '{kind: kind, identifier: id, value: val,
                                 payload_byte: pb, pair_part: pp, last: 1'b0};
        step_n++;
    endtask

    task automatic predict_parse(input logic [7:0] b, input logic start);
        logic done;
        logic aborted;
        int   i;
        done    = 1'b0;
        aborted = 1'b0;
        step_n  = 0;
        if (start) begin
            clear_parse_state();
            ph = mpbp_pkg::PH_LEN;
        end
        if (ph == mpbp_pkg::PH_LEN) begin
            blk_left = blk_left | (32'(b[6:0]) << (7 * vshift));
            if (b[7]) begin
                if (vshift == 2'd3) begin
                    add_record(mpbp_pkg::K_BLK_ERR, 8'd0, 32'(prop_cnt), 8'd0, 1'b0);
                    ph = mpbp_pkg::PH_DONE;
                end else begin
                    vshift = vshift + 2'd1;
                end
            end else begin
                vshift = 2'd0;
                if (blk_left == 32'd0) begin
                    add_record(mpbp_pkg::K_BLK_OK, 8'd0, 32'd0, 8'd0, 1'b0);
                    ph = mpbp_pkg::PH_DONE;
                end else begin
                    ph = mpbp_pkg::PH_ID;
                end
            end
        end else if (ph >= mpbp_pkg::PH_ID && ph <= mpbp_pkg::PH_SDATA) begin
            if (blk_left != 32'd0) blk_left = blk_left - 32'd1;
            unique case (ph)
                mpbp_pkg::PH_ID: begin
                    cur_id   = b;
                    cur_type = prop_type_of(b);
                    pair_val = 1'b0;
                    acc      = '0;
                    vshift   = '0;
                    unique case (cur_type)
                        mpbp_pkg::T_UNKNOWN: begin
                            add_record(mpbp_pkg::K_UNKNOWN, cur_id, 32'd0, 8'd0, 1'b0);
                            done = 1'b1;
                        end
                        mpbp_pkg::T_BYTE: begin
                            fld_left = 16'd1;
                            ph = mpbp_pkg::PH_NUM;
                        end
                        mpbp_pkg::T_TWO: begin
                            fld_left = 16'd2;
                            ph = mpbp_pkg::PH_NUM;
                        end
                        mpbp_pkg::T_FOUR: begin
                            fld_left = 16'd4;
                            ph = mpbp_pkg::PH_NUM;
                        end
                        mpbp_pkg::T_VAR: ph = mpbp_pkg::PH_PVAR;
                        default:         ph = mpbp_pkg::PH_SLEN_HI;
                    endcase
                end
                mpbp_pkg::PH_NUM: begin
                    acc = {acc[23:0], b};
                    if (fld_left != 16'd0) fld_left = fld_left - 16'd1;
                    if (fld_left == 16'd0) begin
                        add_record(mpbp_pkg::K_NUMERIC, cur_id, acc, 8'd0, 1'b0);
                        done = 1'b1;
                    end
                end
                mpbp_pkg::PH_PVAR: begin
                    acc = acc | (32'(b[6:0]) << (7 * vshift));
                    if (b[7]) begin
                        if (vshift == 2'd3) begin
                            add_record(mpbp_pkg::K_BLK_ERR, 8'd0, 32'(prop_cnt),
                                       8'd0, 1'b0);
                            ph = mpbp_pkg::PH_DONE;
                            aborted = 1'b1;
                        end else begin
                            vshift = vshift + 2'd1;
                        end
                    end else begin
                        add_record(mpbp_pkg::K_NUMERIC, cur_id, acc, 8'd0, 1'b0);
                        done = 1'b1;
                    end
                end
                mpbp_pkg::PH_SLEN_HI: begin
                    fld_left = {b, 8'd0};
                    ph = mpbp_pkg::PH_SLEN_LO;
                end
                mpbp_pkg::PH_SLEN_LO: begin
                    fld_left[7:0] = b;
                    add_record(mpbp_pkg::K_STR_HDR, cur_id, 32'(fld_left), 8'd0, pair_val);
                    ph = mpbp_pkg::PH_SDATA;
                end
                default: begin
                    add_record(mpbp_pkg::K_STR_BYTE, cur_id, 32'd0, b, pair_val);
                    if (fld_left != 16'd0) fld_left = fld_left - 16'd1;
                end
            endcase
            if (!aborted) begin
                if (ph == mpbp_pkg::PH_SDATA && fld_left == 16'd0) begin
                    if (cur_type == mpbp_pkg::T_PAIR && !pair_val) begin
                        pair_val = 1'b1;
                        ph = mpbp_pkg::PH_SLEN_HI;
                    end else begin
                        done = 1'b1;
                    end
                end
                if (done) begin
                    prop_cnt = prop_cnt + 8'd1;
                    if (blk_left == 32'd0) begin
                        add_record(mpbp_pkg::K_BLK_OK, 8'd0, 32'(prop_cnt), 8'd0, 1'b0);
                        ph = mpbp_pkg::PH_DONE;
                    end else if (prop_cnt >= 8'(mpbp_pkg::MAX_PROPERTIES)) begin
                        add_record(mpbp_pkg::K_BLK_ERR, 8'd0, 32'(prop_cnt), 8'd0, 1'b0);
                        ph = mpbp_pkg::PH_DONE;
                    end else begin
                        ph = mpbp_pkg::PH_ID;
                    end
                end else if (blk_left == 32'd0) begin
                    add_record(mpbp_pkg::K_BLK_ERR, 8'd0, 32'(prop_cnt), 8'd0, 1'b0);
                    ph = mpbp_pkg::PH_DONE;
                end
            end
        end
        if (step_n > 0) step_records[step_n - 1].last = 1'b1;
        for (i = 0; i < step_n; i++) expected_records.push_back(step_records[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic start);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_start_block <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        predict_parse(b, start);
    endtask

    task automatic send_section(input logic [31:0] length, input int pad);
        int   ng;
        int   i;
        logic cont;
        ng = 1;
        while (ng < 4 && (length >> (7 * ng)) != 0) ng++;
        ng = (ng + pad > 4) ? 4 : ng + pad;
        for (i = 0; i < ng; i++) begin
            cont = (i != ng - 1);
            send_byte({cont, 7'(length >> (7 * i))}, i == 0);
        end
        foreach (body[k]) send_byte(body[k], 1'b0);
    endtask

    task automatic add_string();
        int len;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 300) : $urandom_range(0, 5);
        body.push_back(8'(len >> 8));
        body.push_back(8'(len));
        repeat (len) body.push_back(8'($urandom));
    endtask

    task automatic add_property();
        logic [7:0] id;
        int         sel;
        int         ng;
        int         i;
        logic       cont;
        sel = $urandom_range(0, 19);
        if (sel < 3) begin
            do id = 8'($urandom); while (prop_type_of(id) != mpbp_pkg::T_UNKNOWN);
        end else if (sel < 5) begin
            id = 8'h0B;
        end else if (sel < 7) begin
            id = 8'h26;
        end else begin
            id = known_ids[$urandom_range(0, 26)];
        end
        body.push_back(id);
        unique case (prop_type_of(id))
            mpbp_pkg::T_BYTE:  repeat (1) body.push_back(8'($urandom));
            mpbp_pkg::T_TWO:   repeat (2) body.push_back(8'($urandom));
            mpbp_pkg::T_FOUR:  repeat (4) body.push_back(8'($urandom));
            mpbp_pkg::T_VAR: begin
                ng = ($urandom_range(0, 24) == 0) ? 5 : $urandom_range(1, 4);
                for (i = 0; i < ng; i++) begin
                    cont = (i != ng - 1);
                    body.push_back({cont, 7'($urandom)});
                end
            end
            mpbp_pkg::T_PAIR: begin
                add_string();
                add_string();
            end
            mpbp_pkg::T_UNKNOWN: ;
            default: add_string();
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                $error("result with none pending: kind %0d id %0h", m_kind, m_identifier);
                err_count++;
            end else begin
                want = expected_records.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_kind));
                check_field("identifier", 32'(want.identifier), 32'(m_identifier));
                check_field("value", want.value, m_value);
                check_field("payload_byte", 32'(want.payload_byte), 32'(m_payload_byte));
                check_field("pair_part", 32'(want.pair_part), 32'(m_pair_part));
                check_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_stalls && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic test_empty_and_stray();
        send_byte(8'h5A, 1'b0);
        body.delete();
        send_section(32'd0, 0);
        send_byte(8'h01, 1'b0);
    endtask

    task automatic test_numeric_types();
        body = '{8'h01, 8'hFF, 8'h13, 8'hAB, 8'hCD, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'h18, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0B, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                 8'h0B, 8'h00};
        send_section(32'(body.size()), 0);
    endtask

    task automatic test_strings_and_pairs();
        body = '{8'h1F, 8'h00, 8'h02, 8'h41, 8'h42, 8'h26, 8'h00, 8'h00, 8'h00, 8'h01,
                 8'h7E, 8'h16, 8'h00, 8'h00};
        send_section(32'(body.size()), 0);
    endtask

    task automatic test_unknown_ids();
        body = '{8'h00, 8'hFF};
        send_section(32'(body.size()), 0);
    endtask

    task automatic test_overlong_length();
        send_byte(8'hFF, 1'b1);
        repeat (3) send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_overlong_prop_varint();
        body = '{8'h0B, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01};
        send_section(32'(body.size()), 0);
    endtask

    task automatic test_length_exhausted();
        body = '{8'h03, 8'h00, 8'h05};
        send_section(32'd3, 0);
        body = '{8'h13, 8'h12};
        send_section(32'd2, 0);
    endtask

    task automatic test_count_limit();
        body.delete();
        repeat (17) body.push_back(8'hFE);
        send_section(32'd17, 0);
        void'(body.pop_back());
        send_section(32'd16, 0);
    endtask

    task automatic test_restart();
        body = '{8'h03, 8'h00, 8'h09, 8'h78};
        send_section(32'h0FFF_FFFF, 0);
        body.delete();
        send_section(32'd0, 0);
    endtask

    task automatic test_random_sections();
        int          n;
        int          i;
        int          sel;
        int          mut;
        logic [31:0] len;
        while (bytes_sent < ITEM_TARGET) begin
            if (bytes_sent > ITEM_TARGET * 17 / 20) begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end else begin
                tx_gaps   = ($urandom_range(0, 3) != 0);
                rx_stalls = ($urandom_range(0, 3) != 0);
            end
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                n = $urandom_range(1, 12);
                for (i = 0; i < n; i++) send_byte(8'($urandom), i == 0);
            end else if (sel == 1) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end else begin
                body.delete();
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
                repeat (n) add_property();
                len = 32'(body.size());
                mut = $urandom_range(0, 9);
                if (mut == 0 && len > 0) len = $urandom_range(0, len - 1);
                else if (mut == 1) len = len + $urandom_range(1, 3);
                send_section(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = 8'd0;
        s_start_block = 1'b0;
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;
        ph            = mpbp_pkg::PH_IDLE;
        clear_parse_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_and_stray();
        test_numeric_types();
        test_strings_and_pairs();
        test_unknown_ids();
        test_overlong_length();
        test_overlong_prop_varint();
        test_length_exhausted();
        test_count_limit();
        test_restart();
        test_random_sections();

        s_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
